// ===== sv/stereo_noise_gate_assert.svh =====
// Assertion macros for the stereo noise gate checks.
`ifndef STEREO_NOISE_GATE_ASSERT_SVH
`define STEREO_NOISE_GATE_ASSERT_SVH

// Same-cycle implication, reset held off.
`define SNG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stereo_noise_gate check failed");

// Next-cycle implication, reset held off.
`define SNG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stereo_noise_gate check failed");

// Implication after a fixed number of cycles, reset held off.
`define SNG_ASSERT_AFTER(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("stereo_noise_gate check failed");

`endif

// ===== sv/sng_pkg.sv =====
package sng_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [15:0]        cfg_word_t;
  typedef logic [1:0]         cfg_idx_t;
  typedef logic [16:0]        gain_t;

  // Register indexes on the configuration port
  localparam cfg_idx_t CFG_OPEN_THR  = 2'd0;
  localparam cfg_idx_t CFG_CLOSE_THR = 2'd1;
  localparam cfg_idx_t CFG_ATTACK    = 2'd2;
  localparam cfg_idx_t CFG_RELEASE   = 2'd3;

  // Register reset values
  localparam cfg_word_t OPEN_THR_RST  = 16'd328;
  localparam cfg_word_t CLOSE_THR_RST = 16'd164;
  localparam cfg_word_t ATTACK_RST    = 16'd0;
  localparam cfg_word_t RELEASE_RST   = 16'd0;

  // Unity gain in Q1.16
  localparam gain_t GAIN_ONE = 17'h10000;

  // Rounding offsets and Q15 limits
  localparam logic [34:0] CEIL_OFS  = 35'd65535;
  localparam logic [33:0] ROUND_OFS = 34'd32768;
  localparam logic [16:0] POS_MAX   = 17'd32767;
  localparam logic [16:0] NEG_MAX   = 17'd32768;

  // Operand selection for the shared multiplier
  localparam logic MUL_DK = 1'b0;
  localparam logic MUL_GM = 1'b1;

  // Command group from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic ch;
    logic gate;
    logic mul_en;
    logic mul_sel;
    logic step;
    logic round;
    logic load_out;
  } sng_cmd_t;

endpackage

// ===== sv/sng_if.sv =====
interface sng_in_if;
  import sng_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;
  logic    block_last;

  modport source (output valid, output sample_left, output sample_right,
                  output block_last, input ready);
  modport sink   (input valid, input sample_left, input sample_right,
                  input block_last, output ready);
endinterface

interface sng_out_if;
  import sng_pkg::*;

  logic    valid;
  logic    ready;
  sample_t gated_left;
  sample_t gated_right;
  logic    block_last_out;

  modport source (output valid, output gated_left, output gated_right,
                  output block_last_out, input ready);
  modport sink   (input valid, input gated_left, input gated_right,
                  input block_last_out, output ready);
endinterface

// ===== sv/stereo_noise_gate.sv =====
// Flow: a frame beat accepted in idle runs through the gate, multiply, step, multiply and
// round states for the left channel, then the right, and is loaded into the output register
// when that register is free; a stalled output adds the stall. One shared 17x17 multiplier is
// used twice per channel (gain step, then gain times sample); no new frame enters until done.
// The output register lets a new frame enter while the last result still waits.
// Reset (rst_n low, synchronous): gates closed, gains zero, configuration registers to defaults.
module stereo_noise_gate (
  input  logic               clk,
  input  logic               rst_n,
  sng_in_if.sink             in_frame,
  sng_out_if.source          out_frame,
  input  logic               cfg_we,
  input  sng_pkg::cfg_idx_t  cfg_index,
  input  sng_pkg::cfg_word_t cfg_data
);
  import sng_pkg::*;

  sng_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;
  sample_t  gated_left;
  sample_t  gated_right;
  logic     block_last_out;

  // Sequencer
  sng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_frame.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_frame.ready),
    .cmd       (cmd)
  );

  // Gate arithmetic and state
  sng_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_left    (in_frame.sample_left),
    .sample_right   (in_frame.sample_right),
    .block_last     (in_frame.block_last),
    .gated_left     (gated_left),
    .gated_right    (gated_right),
    .block_last_out (block_last_out)
  );

  assign in_frame.ready           = in_ready;
  assign out_frame.valid          = out_valid;
  assign out_frame.gated_left     = gated_left;
  assign out_frame.gated_right    = gated_right;
  assign out_frame.block_last_out = block_last_out;

endmodule

// ===== sv/sng_datapath.sv =====
module sng_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sng_pkg::sng_cmd_t    cmd,
  input  logic                 cfg_we,
  input  sng_pkg::cfg_idx_t    cfg_index,
  input  sng_pkg::cfg_word_t   cfg_data,
  input  sng_pkg::sample_t     sample_left,
  input  sng_pkg::sample_t     sample_right,
  input  logic                 block_last,
  output sng_pkg::sample_t     gated_left,
  output sng_pkg::sample_t     gated_right,
  output logic                 block_last_out
);
  import sng_pkg::*;

  cfg_word_t open_thr_r, close_thr_r, attack_r, release_r;
  sample_t   samp_lf_r, samp_rt_r;
  logic      last_r;
  gain_t     gain_lf_r, gain_rt_r;
  logic      open_lf_r, open_rt_r;
  logic [15:0] mag_r;
  gain_t     d_r, k_r;
  logic      up_r;
  logic [33:0] prod_r;
  sample_t   res_lf_r, res_rt_r;
  sample_t   gated_lf_r, gated_rt_r;
  logic      last_out_r;

  sample_t     x;
  gain_t       g_cur;
  logic        open_cur, open_new;
  logic [15:0] mag;
  cfg_word_t   coef;
  gain_t       k_nxt, d_nxt;
  gain_t       mul_a, mul_b;
  logic [33:0] product;
  logic [34:0] ceil_sum;
  gain_t       step;
  logic [17:0] g_sum;
  gain_t       g_new;
  logic [33:0] rnd_sum;
  logic [16:0] r, r_sat;
  sample_t     y;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r  <= OPEN_THR_RST;
      close_thr_r <= CLOSE_THR_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN_THR:  open_thr_r  <= cfg_data;
        CFG_CLOSE_THR: close_thr_r <= cfg_data;
        CFG_ATTACK:    attack_r    <= cfg_data;
        CFG_RELEASE:   release_r   <= cfg_data;
      endcase
    end
  end

  // Channel selection
  always_comb begin
    x        = cmd.ch ? samp_rt_r : samp_lf_r;
    g_cur    = cmd.ch ? gain_rt_r : gain_lf_r;
    open_cur = cmd.ch ? open_rt_r : open_lf_r;
  end

  // Magnitude, gate hysteresis, smoothing distance and pole
  always_comb begin
    mag      = x[15] ? (~x + 16'd1) : x;
    open_new = open_cur ? !(mag <= close_thr_r) : (mag >= open_thr_r);
    coef     = open_new ? attack_r : release_r;
    k_nxt    = GAIN_ONE - {1'b0, coef};
    d_nxt    = open_new ? (GAIN_ONE - g_cur) : g_cur;
  end

  // Shared multiplier
  always_comb begin
    mul_a   = (cmd.mul_sel == MUL_DK) ? d_r : g_cur;
    mul_b   = (cmd.mul_sel == MUL_DK) ? k_r : {1'b0, mag_r};
    product = mul_a * mul_b;
  end

  // Ceiling step and gain move, clamped to unity
  always_comb begin
    ceil_sum = {1'b0, prod_r} + CEIL_OFS;
    step     = ceil_sum[32:16];
    g_sum    = up_r ? ({1'b0, g_cur} + {1'b0, step}) : ({1'b0, g_cur} - {1'b0, step});
    g_new    = (g_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : g_sum[16:0];
  end

  // Round half away from zero, saturate to Q15 with the sample's sign
  always_comb begin
    rnd_sum = prod_r + ROUND_OFS;
    r       = rnd_sum[32:16];
    if (x[15]) begin
      r_sat = (r > NEG_MAX) ? NEG_MAX : r;
      y     = sample_t'(~r_sat + 17'd1);
    end else begin
      r_sat = (r > POS_MAX) ? POS_MAX : r;
      y     = sample_t'(r_sat);
    end
  end

  // Channel state: gate flags and gains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_lf_r <= 1'b0;
      open_rt_r <= 1'b0;
      gain_lf_r <= '0;
      gain_rt_r <= '0;
    end else begin
      if (cmd.gate) begin
        if (cmd.ch) open_rt_r <= open_new;
        else        open_lf_r <= open_new;
      end
      if (cmd.step) begin
        if (cmd.ch) gain_rt_r <= g_new;
        else        gain_lf_r <= g_new;
      end
    end
  end

  // Working registers and frame capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      samp_lf_r <= sample_left;
      samp_rt_r <= sample_right;
      last_r    <= block_last;
    end
    if (cmd.gate) begin
      mag_r <= mag;
      d_r   <= d_nxt;
      k_r   <= k_nxt;
      up_r  <= open_new;
    end
    if (cmd.mul_en) begin
      prod_r <= product;
    end
    if (cmd.round) begin
      if (cmd.ch) res_rt_r <= y;
      else        res_lf_r <= y;
    end
    if (cmd.load_out) begin
      gated_lf_r <= res_lf_r;
      gated_rt_r <= res_rt_r;
      last_out_r <= last_r;
    end
  end

  assign gated_left     = gated_lf_r;
  assign gated_right    = gated_rt_r;
  assign block_last_out = last_out_r;

endmodule

// ===== sv/sng_ctrl.sv =====
module sng_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sng_pkg::sng_cmd_t cmd
);
  import sng_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GATE  = 3'd1;
  localparam logic [2:0] S_MULD  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_MULG  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequence both channels through the shared datapath, then load the output
  always_comb begin
    state_nxt    = state_r;
    ch_nxt       = ch_r;
    cmd          = '0;
    cmd.ch       = ch_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
        ch_nxt      = 1'b0;
        if (in_valid) state_nxt = S_GATE;
      end
      S_GATE: begin
        cmd.gate  = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DK;
        state_nxt   = S_STEP;
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_MULG;
      end
      S_MULG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GM;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (ch_r) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = S_GATE;
        end
      end
      S_DONE: begin
        cmd.load_out = out_free;
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)      out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/sng_checker.sv =====
`include "stereo_noise_gate_assert.svh"

module sng_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sng_pkg::sample_t gated_left,
  input sng_pkg::sample_t gated_right,
  input logic             block_last_out
);
  import sng_pkg::*;

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // One frame at a time: no new beat while a frame is in work
  `SNG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_beat, !in_ready)

  // Both channels take the full sequence before the next frame can enter
  `SNG_ASSERT_AFTER(a_busy_whole_frame, clk, rst_n, in_beat, 11, !in_ready)

  // A stalled result beat stays and holds its payload
  `SNG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
    out_valid && $stable(gated_left) && $stable(gated_right) && $stable(block_last_out))

endmodule

bind stereo_noise_gate sng_checker u_sng_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_frame.valid),
  .in_ready       (in_frame.ready),
  .out_valid      (out_frame.valid),
  .out_ready      (out_frame.ready),
  .gated_left     (out_frame.gated_left),
  .gated_right    (out_frame.gated_right),
  .block_last_out (out_frame.block_last_out)
);
